[hdl/rgcd_pkg.sv]
package rgcd_pkg;

   // Width of the distance and the running divisor
   localparam int VALUE_BITS = 32;
   localparam int SHIFT_BITS = $clog2(VALUE_BITS);
   localparam int POS_BITS   = 32;
   localparam int DIFF_BITS  = POS_BITS + 1;
   localparam int OUT_BITS   = 32;

   typedef logic [VALUE_BITS-1:0] value_type;
   typedef logic [SHIFT_BITS-1:0] shift_type;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SETUP = 4'b0010,
      ST_RUN   = 4'b0100,
      ST_SEND  = 4'b1000
   } state_type;

endpackage

[hdl/running_gcd_of_distances.sv]
// Running GCD of distances. Each transaction on req carries a signed position
// (tdata) and a first-of-set flag (tuser). The block forms |position - reference|,
// saturated to VALUE_BITS, and folds it into the running greatest common divisor,
// which restarts from this distance when the flag is set; one result per item
// comes back on rsp. gcd(0,0) is 0, and a zero distance leaves the value as is.
// The item is taken into the difference register, the saturated distance is
// then loaded into the operands, then one shared shift/subtract unit (binary GCD)
// runs one step per cycle until either operand is zero, and the result is loaded
// into the output register once the previous result has been taken on rsp_tready.
// req_tready is low while an item is in work. The user must write the reference
// point on csr only while idle; the block itself does not enforce it.
module running_gcd_of_distances
   import rgcd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   // tdata: [31:0] position
   input  logic [POS_BITS-1:0] req_tdata,
   // tuser: [0] first_of_set
   input  logic                req_tuser,
   input  logic                req_tvalid,
   output logic                req_tready,
   // tdata: [31:0] common_divisor
   output logic [OUT_BITS-1:0] rsp_tdata,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  logic [POS_BITS-1:0] csr_data,
   input  logic                csr_valid,
   output logic                csr_ready
);

   state_type            state_ff, state_in;
   logic [POS_BITS-1:0]  ref_ff;
   logic [DIFF_BITS-1:0] diff_ff, diff_in;
   logic                 first_ff, first_in;
   value_type            a_ff, a_in, b_ff, b_in;
   shift_type            k_ff, k_in;
   value_type            div_ff, div_in;
   logic [OUT_BITS-1:0]  out_ff, out_in;
   logic                 out_vld_ff, out_vld_in;

   logic [DIFF_BITS-1:0] abs_dist;
   value_type            dist_sat;
   value_type            gcd_res;
   value_type            sub_res;
   logic                 a_ge_b;
   logic                 out_free;

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_ff;
   assign out_free   = !out_vld_ff || rsp_tready;

   // distance, saturated to the value width
   always_comb begin
      abs_dist = diff_ff[DIFF_BITS-1] ? (~diff_ff + DIFF_BITS'(1)) : diff_ff;
      if ((abs_dist >> VALUE_BITS) != '0) begin
         dist_sat = '1;
      end else begin
         dist_sat = VALUE_BITS'(abs_dist);
      end
   end

   // shared step unit
   assign a_ge_b  = (a_ff >= b_ff);
   assign sub_res = a_ge_b ? (a_ff - b_ff) : (b_ff - a_ff);
   assign gcd_res = (a_ff | b_ff) << k_ff;

   always_comb begin
      state_in   = state_ff;
      diff_in    = diff_ff;
      first_in   = first_ff;
      a_in       = a_ff;
      b_in       = b_ff;
      k_in       = k_ff;
      div_in     = div_ff;
      out_in     = out_ff;
      out_vld_in = out_vld_ff;
      if (out_vld_ff && rsp_tready) begin
         out_vld_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               diff_in  = {req_tdata[POS_BITS-1], req_tdata} -
                          {ref_ff[POS_BITS-1], ref_ff};
               first_in = req_tuser;
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            a_in     = first_ff ? '0 : div_ff;
            b_in     = dist_sat;
            k_in     = '0;
            state_in = ST_RUN;
         end
         ST_RUN: begin
            if (a_ff == '0 || b_ff == '0) begin
               // keep only the bits the result port can carry
               div_in   = VALUE_BITS'(OUT_BITS'(gcd_res));
               state_in = ST_SEND;
            end else if (!a_ff[0] && !b_ff[0]) begin
               a_in = a_ff >> 1;
               b_in = b_ff >> 1;
               k_in = k_ff + SHIFT_BITS'(1);
            end else if (!a_ff[0]) begin
               a_in = a_ff >> 1;
            end else if (!b_ff[0]) begin
               b_in = b_ff >> 1;
            end else if (a_ge_b) begin
               // both odd: difference is even
               a_in = sub_res >> 1;
            end else begin
               b_in = sub_res >> 1;
            end
         end
         ST_SEND: begin
            if (out_free) begin
               out_in     = OUT_BITS'(div_ff);
               out_vld_in = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         ref_ff     <= '0;
         div_ff     <= '0;
         out_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         div_ff     <= div_in;
         out_vld_ff <= out_vld_in;
         if (csr_valid && csr_ready) begin
            ref_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      diff_ff  <= diff_in;
      first_ff <= first_in;
      a_ff     <= a_in;
      b_ff     <= b_in;
      k_ff     <= k_in;
      out_ff   <= out_in;
   end

endmodule

[hdl/rgcd_checker.sv]
module rgcd_checker
   import rgcd_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic [POS_BITS-1:0] req_tdata,
   input logic                req_tuser,
   input logic                req_tvalid,
   input logic                req_tready,
   input logic [OUT_BITS-1:0] rsp_tdata,
   input logic                rsp_tvalid,
   input logic                rsp_tready
);

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp changed while stalled");

   // a waiting request holds
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && !req_tready |=>
         req_tvalid && $stable(req_tdata) && $stable(req_tuser))
      else $error("req changed while waiting");

   // busy right after an accepted item
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("req_tready high right after accept");

   // ready only drops because an item was taken
   assert property (@(posedge clock) disable iff (reset)
      $fell(req_tready) |-> $past(req_tvalid))
      else $error("req_tready fell without a transaction");

   // a new result appears as the unit goes idle
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> req_tready)
      else $error("result issued while busy");

endmodule

bind running_gcd_of_distances rgcd_checker u_rgcd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready)
);

[sim/tb_running_gcd_of_distances.sv]
`timescale 1ns / 1ps

module tb_running_gcd_of_distances;
   import rgcd_pkg::*;

   localparam int          STALL_LIMIT = 5000;
   localparam int          SETTLE_CYCLES = 80;
   localparam logic [63:0] DIST_MAX = (64'd1 << VALUE_BITS) - 64'd1;

   typedef struct {
      logic [POS_BITS-1:0] position;
      logic                first_of_set;
   } target_item_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic [POS_BITS-1:0] req_tdata = '0;
   logic                req_tuser = 1'b0;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [OUT_BITS-1:0] rsp_tdata;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [POS_BITS-1:0] csr_data = '0;
   logic                csr_valid = 1'b0;
   logic                csr_ready;

   target_item_type     pending_targets[$];
   logic [OUT_BITS-1:0] divisor_expected[$];
   logic [POS_BITS-1:0] reference_value = '0;
   logic [OUT_BITS-1:0] running_divisor = '0;
   logic                no_gaps = 1'b0;
   int                  mismatch_count = 0;
   int                  quiet_cycles = 0;

   running_gcd_of_distances uut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_data   (csr_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready)
   );

   always #5 clock = ~clock;

   task automatic report_mismatch(string msg);
      $display("ERROR @%0t: %s", $time, msg);
      mismatch_count++;
   endtask

   function automatic logic [63:0] euclid_gcd(logic [63:0] a, logic [63:0] b);
      logic [63:0] r;
      while (b != 0) begin
         r = a % b;
         a = b;
         b = r;
      end
      return a;
   endfunction

   // Next running divisor for one target; distance is exact in 64 bits, then saturated
   function automatic logic [OUT_BITS-1:0] fold_distance(logic [POS_BITS-1:0] pos,
                                                         logic first);
      longint      diff;
      logic [63:0] dist_sat;
      logic [63:0] folded;
      diff = longint'($signed(pos)) - longint'($signed(reference_value));
      if (diff < 0)
         diff = -diff;
      dist_sat = diff;
      if (dist_sat > DIST_MAX)
         dist_sat = DIST_MAX;
      if (first)
         folded = dist_sat;
      else
         folded = euclid_gcd({32'd0, running_divisor}, dist_sat);
      folded &= DIST_MAX;
      return folded[OUT_BITS-1:0];
   endfunction

   // Driver: predicts on each accepted transaction, then loads the next target
   always @(posedge clock) begin
      target_item_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            running_divisor = fold_distance(req_tdata, req_tuser);
            divisor_expected.push_back(running_divisor);
         end
         if (!req_tvalid || req_tready) begin
            if (pending_targets.size() != 0 && (no_gaps || $urandom_range(99) >= 20)) begin
               nxt = pending_targets.pop_front();
               req_tdata  <= nxt.position;
               req_tuser  <= nxt.first_of_set;
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Monitor
   always @(posedge clock) begin
      logic [OUT_BITS-1:0] want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (divisor_expected.size() == 0) begin
               report_mismatch($sformatf("unexpected result %h", rsp_tdata));
            end else begin
               want = divisor_expected.pop_front();
               if (rsp_tdata !== want)
                  report_mismatch($sformatf("common_divisor %h, expected %h",
                                            rsp_tdata, want));
            end
         end
         rsp_tready <= no_gaps || ($urandom_range(99) >= 20);
      end
   end

   // Watchdog on cycles without any transaction
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
         $display("Simulation FAILED");
         $finish;
      end
   end

   task automatic push_target(logic [POS_BITS-1:0] pos, logic first);
      target_item_type t;
      t.position     = pos;
      t.first_of_set = first;
      pending_targets.push_back(t);
   endtask

   // Sender holds off until every result is back
   task automatic drain;
      do @(negedge clock);
      while (pending_targets.size() != 0 || req_tvalid || divisor_expected.size() != 0);
   endtask

   task automatic write_reference(logic [POS_BITS-1:0] value);
      @(posedge clock);
      csr_data  <= value;
      csr_valid <= 1'b1;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      reference_value = value;
      @(negedge clock);
   endtask

   // Mostly sets of points on a common lattice around the reference, some noise
   task automatic queue_random_targets(int count);
      int                  placed;
      int                  set_len;
      logic [31:0]         factor;
      logic [31:0]         step;
      logic [POS_BITS-1:0] pos;
      placed = 0;
      while (placed < count) begin
         if ($urandom_range(99) < 75) begin
            set_len = $urandom_range(1, 8);
            factor  = $urandom_range(1, 1 << $urandom_range(0, 20));
            for (int j = 0; j < set_len; j++) begin
               step = factor * $urandom_range(0, 255);
               pos  = $urandom_range(1) ? reference_value + step : reference_value - step;
               // occasionally the set continues the previous one
               push_target(pos, j == 0 && $urandom_range(9) != 0);
               placed++;
            end
         end else begin
            push_target($urandom(), $urandom_range(1));
            placed++;
         end
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reference at reset value 0; no first mark yet
      push_target(32'd0, 1'b0);
      push_target(32'd12, 1'b0);
      push_target(-32'sd18, 1'b0);
      push_target(32'd0, 1'b0);
      push_target(32'd7, 1'b1);
      push_target(32'h8000_0000, 1'b1);
      push_target(32'h7FFF_FFFF, 1'b0);
      push_target(32'hFFFF_FFFF, 1'b1);
      push_target(32'd0, 1'b1);
      push_target(32'd0, 1'b0);
      drain();

      // largest distances, both directions
      write_reference(32'h8000_0000);
      push_target(32'h7FFF_FFFF, 1'b1);
      push_target(32'h8000_0000, 1'b0);
      push_target(32'h8000_0003, 1'b0);
      drain();
      write_reference(32'h7FFF_FFFF);
      push_target(32'h8000_0000, 1'b1);
      push_target(32'h7FFF_FFFF, 1'b0);
      push_target(32'hFFFF_FFFF, 1'b0);
      drain();
      write_reference(32'd1000);
      push_target(32'd1360, 1'b1);
      push_target(32'd640, 1'b0);
      push_target(32'd1024, 1'b0);
      drain();

      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            1:       write_reference(32'h8000_0000);
            2:       write_reference(32'h7FFF_FFFF);
            3:       write_reference($urandom_range(0, 4095));
            4:       write_reference(32'hFFFF_FFFF);
            6:       write_reference(32'd0);
            default: write_reference($urandom());
         endcase
         no_gaps = (phase == 3);
         queue_random_targets(192);
         drain();
      end
      no_gaps = 1'b0;

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (divisor_expected.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", divisor_expected.size()));
      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
